[hdl/vn_pkg.sv]
// shared widths, step counts and pipeline word types for the vector normaliser
`timescale 1ns / 1ps
package vn_pkg;

  localparam int unsigned COMP_W     = 16;
  localparam int unsigned SUMSQ_W    = 32;
  localparam int unsigned ROOT_STEPS = SUMSQ_W / 2;
  localparam int unsigned DIV_STEPS  = COMP_W;
  localparam int unsigned FRONT_LAT  = 3;
  localparam int unsigned PIPE_LAT   = FRONT_LAT + ROOT_STEPS + DIV_STEPS + 1;

  localparam logic [COMP_W-1:0] Q15_MAX = 16'h7fff;

  typedef logic [COMP_W-1:0]  comp_t;
  typedef logic [SUMSQ_W-1:0] sumsq_t;

  // side data that rides alongside the square root stages
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
    comp_t      ax;
    comp_t      ay;
    comp_t      az;
  } root_side_t;

  // side data that rides alongside the divider stages
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } div_side_t;

endpackage

[hdl/vn_sqrt.sv]
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module vn_sqrt (
  input  logic           clk,
  input  vn_pkg::sumsq_t rad,
  output vn_pkg::comp_t  root
);
  import vn_pkg::*;

  logic [SUMSQ_W-1:0] rad_s  [1:ROOT_STEPS-1];
  logic [COMP_W-1:0]  rem_s  [1:ROOT_STEPS-1];
  logic [COMP_W-1:0]  root_s [1:ROOT_STEPS];
  logic [SUMSQ_W-1:0] rad_in  [0:ROOT_STEPS-1];
  logic [COMP_W-1:0]  rem_in  [0:ROOT_STEPS-1];
  logic [COMP_W-1:0]  root_in [0:ROOT_STEPS-1];
  logic [COMP_W-1:0]  rem_next  [0:ROOT_STEPS-2];
  logic [COMP_W-1:0]  root_next [0:ROOT_STEPS-1];

  // stage inputs: the incoming radicand first, then the stage registers
  always_comb begin
    rad_in[0]  = rad;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < ROOT_STEPS; k++) begin
      rad_in[k]  = rad_s[k];
      rem_in[k]  = rem_s[k];
      root_in[k] = root_s[k];
    end
  end

  // one digit pair per stage: shift in two bits, try root*4+1
  always_comb begin
    logic [COMP_W+1:0] rem_sh;
    logic [COMP_W+1:0] trial;
    logic              take;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rem_sh = {rem_in[k], rad_in[k][2*(ROOT_STEPS-1-k)+1 -: 2]};
      trial  = {root_in[k], 2'b01};
      take   = (rem_sh >= trial);
      root_next[k] = {root_in[k][COMP_W-2:0], take};
      // the last stage keeps only the root bit
      if (k < ROOT_STEPS-1) begin
        rem_next[k] = take ? COMP_W'(rem_sh - trial) : COMP_W'(rem_sh);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_STEPS-1; k++) begin
      rad_s[k+1] <= rad_in[k];
      rem_s[k+1] <= rem_next[k];
    end
    for (int k = 0; k < ROOT_STEPS; k++) begin
      root_s[k+1] <= root_next[k];
    end
  end

  assign root = root_s[ROOT_STEPS];

endmodule

[hdl/vn_div.sv]
// pipelined restoring divider for (a * 32768) / d, one quotient bit per stage
`timescale 1ns / 1ps
module vn_div (
  input  logic          clk,
  input  vn_pkg::comp_t num,
  input  vn_pkg::comp_t den,
  output vn_pkg::comp_t quot
);
  import vn_pkg::*;

  logic [COMP_W-1:0] rem_s  [1:DIV_STEPS-1];
  logic [COMP_W-1:0] den_s  [1:DIV_STEPS-1];
  logic [COMP_W-1:0] quot_s [1:DIV_STEPS];
  logic [COMP_W-1:0] rem_in  [0:DIV_STEPS-1];
  logic [COMP_W-1:0] den_in  [0:DIV_STEPS-1];
  logic [COMP_W-1:0] quot_in [0:DIV_STEPS-1];
  logic [COMP_W-1:0] rem_next  [0:DIV_STEPS-2];
  logic [COMP_W-1:0] quot_next [0:DIV_STEPS-1];

  // the top dividend bits are below the divisor, so start past them
  always_comb begin
    rem_in[0]  = {1'b0, num[COMP_W-1:1]};
    den_in[0]  = den;
    quot_in[0] = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_in[k]  = rem_s[k];
      den_in[k]  = den_s[k];
      quot_in[k] = quot_s[k];
    end
  end

  // compare and subtract per stage
  always_comb begin
    logic [COMP_W:0] rem_sh;
    logic            take;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_sh = {rem_in[k], (k == 0) ? num[0] : 1'b0};
      take   = (rem_sh >= {1'b0, den_in[k]});
      quot_next[k] = {quot_in[k][COMP_W-2:0], take};
      // the last stage keeps only the quotient bit
      if (k < DIV_STEPS-1) begin
        rem_next[k] = take ? COMP_W'(rem_sh - {1'b0, den_in[k]}) : COMP_W'(rem_sh);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS-1; k++) begin
      rem_s[k+1] <= rem_next[k];
      den_s[k+1] <= den_in[k];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      quot_s[k+1] <= quot_next[k];
    end
  end

  assign quot = quot_s[DIV_STEPS];

endmodule

[hdl/vector3_normalize_top.sv]
// top level: scales a 3-component vector to unit length in Q1.15
// path from the accepting edge to the edge that takes the result word:
// 3 front stages, 16 root stages, 16 divider stages and the output register
// throughput: one word per cycle, every stage is registered with its own valid bit
// busy is high only during reset; the receiver cannot stall and nothing is held
// reset (rst, synchronous) clears the valid bits; data registers are not reset
`timescale 1ns / 1ps
module vector3_normalize_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  vn_pkg::comp_t x_in,
  input  vn_pkg::comp_t y_in,
  input  vn_pkg::comp_t z_in,
  output logic          done,
  output vn_pkg::comp_t x_out,
  output vn_pkg::comp_t y_out,
  output vn_pkg::comp_t z_out,
  output logic          zero_vector
);
  import vn_pkg::*;

  logic       v1, v2, v3;
  logic [2:0] neg1, neg2, neg3;
  comp_t      ax1, ay1, az1, ax2, ay2, az2, ax3, ay3, az3;
  logic [SUMSQ_W-1:0] sqx2, sqy2, sqz2;
  sumsq_t     sum3;
  logic       zero3;

  logic       rv   [1:ROOT_STEPS];
  root_side_t rsb  [1:ROOT_STEPS];
  logic       dv   [1:DIV_STEPS];
  div_side_t  dsb  [1:DIV_STEPS];
  root_side_t rsb_in;
  div_side_t  dsb_in;

  comp_t      mag;
  comp_t      qx, qy, qz;
  comp_t      ox_next, oy_next, oz_next;

  assign busy = rst;

  // front stage: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    neg1 <= {z_in[COMP_W-1], y_in[COMP_W-1], x_in[COMP_W-1]};
    ax1  <= x_in[COMP_W-1] ? comp_t'(-x_in) : x_in;
    ay1  <= y_in[COMP_W-1] ? comp_t'(-y_in) : y_in;
    az1  <= z_in[COMP_W-1] ? comp_t'(-z_in) : z_in;
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    neg2 <= neg1;
    ax2  <= ax1;
    ay2  <= ay1;
    az2  <= az1;
    sqx2 <= ax1 * ax1;
    sqy2 <= ay1 * ay1;
    sqz2 <= az1 * az1;
  end

  // sum of squares and zero test
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    neg3  <= neg2;
    ax3   <= ax2;
    ay3   <= ay2;
    az3   <= az2;
    sum3  <= sqx2 + sqy2 + sqz2;
    zero3 <= (sqx2 + sqy2 + sqz2) == '0;
  end

  // square root
  vn_sqrt u_sqrt (
    .clk  (clk),
    .rad  (sum3),
    .root (mag)
  );

  assign rsb_in = '{zero: zero3, neg: neg3, ax: ax3, ay: ay3, az: az3};

  // side data delay across the root stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= ROOT_STEPS; k++) rv[k] <= 1'b0;
    end else begin
      rv[1] <= v3;
      for (int k = 2; k <= ROOT_STEPS; k++) rv[k] <= rv[k-1];
    end
    rsb[1] <= rsb_in;
    for (int k = 2; k <= ROOT_STEPS; k++) rsb[k] <= rsb[k-1];
  end

  // three divider lanes
  vn_div u_div_x (.clk(clk), .num(rsb[ROOT_STEPS].ax), .den(mag), .quot(qx));
  vn_div u_div_y (.clk(clk), .num(rsb[ROOT_STEPS].ay), .den(mag), .quot(qy));
  vn_div u_div_z (.clk(clk), .num(rsb[ROOT_STEPS].az), .den(mag), .quot(qz));

  assign dsb_in = '{zero: rsb[ROOT_STEPS].zero, neg: rsb[ROOT_STEPS].neg};

  // side data delay across the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DIV_STEPS; k++) dv[k] <= 1'b0;
    end else begin
      dv[1] <= rv[ROOT_STEPS];
      for (int k = 2; k <= DIV_STEPS; k++) dv[k] <= dv[k-1];
    end
    dsb[1] <= dsb_in;
    for (int k = 2; k <= DIV_STEPS; k++) dsb[k] <= dsb[k-1];
  end

  // sign, saturation and zero override
  always_comb begin
    ox_next = dsb[DIV_STEPS].neg[0] ? comp_t'(-qx) : ((qx > Q15_MAX) ? Q15_MAX : qx);
    oy_next = dsb[DIV_STEPS].neg[1] ? comp_t'(-qy) : ((qy > Q15_MAX) ? Q15_MAX : qy);
    oz_next = dsb[DIV_STEPS].neg[2] ? comp_t'(-qz) : ((qz > Q15_MAX) ? Q15_MAX : qz);
    if (dsb[DIV_STEPS].zero) begin
      ox_next = '0;
      oy_next = '0;
      oz_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DIV_STEPS];
    end
    x_out       <= ox_next;
    y_out       <= oy_next;
    z_out       <= oz_next;
    zero_vector <= dsb[DIV_STEPS].zero;
  end

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(PIPE_LAT) done)
    else $error("result word missing after pipeline latency");

  // a zero vector gives all-zero outputs
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && zero_vector) |-> (x_out == '0 && y_out == '0 && z_out == '0))
    else $error("zero vector with nonzero outputs");

  // a nonzero vector always has a nonzero normalised component
  a_nonzero_out: assert property (@(posedge clk) disable iff (rst)
    (done && !zero_vector) |-> (x_out != '0 || y_out != '0 || z_out != '0))
    else $error("nonzero vector normalised to zero");

endmodule
